FILE: hw/rtl/bdq_pkg.sv
`default_nettype none

package bdq_pkg;

  // Word width of the stored and returned data.
  localparam int unsigned DATA_W = 32;

  // Request operation codes.
  localparam logic [1:0] OP_PUSH_REAR  = 2'd0;
  localparam logic [1:0] OP_PUSH_FRONT = 2'd1;
  localparam logic [1:0] OP_POP_FRONT  = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;     // capture the incoming item
    logic exec;     // perform the queue operation
    logic deliver;  // move the result into the output register
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic res_free; // output register can take a new result this cycle
  } dp_stat_t;

endpackage

`default_nettype wire

FILE: hw/rtl/bdq_ctrl.sv
`default_nettype none

module bdq_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire bdq_pkg::dp_stat_t  stat,
  output bdq_pkg::ctrl_cmd_t      cmd
);

  bdq_pkg::state_t state;
  bdq_pkg::state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bdq_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      bdq_pkg::S_IDLE: begin
        if (in_valid) begin
          state_next = bdq_pkg::S_EXEC;
        end
      end
      bdq_pkg::S_EXEC: begin
        state_next = bdq_pkg::S_DONE;
      end
      bdq_pkg::S_DONE: begin
        if (stat.res_free) begin
          state_next = bdq_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = bdq_pkg::S_IDLE;
      end
    endcase
  end

  // Output decode.
  always_comb begin
    in_ready    = 1'b0;
    cmd.load    = 1'b0;
    cmd.exec    = 1'b0;
    cmd.deliver = 1'b0;
    unique case (state)
      bdq_pkg::S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      bdq_pkg::S_EXEC: begin
        cmd.exec = 1'b1;
      end
      bdq_pkg::S_DONE: begin
        cmd.deliver = stat.res_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: hw/rtl/bdq_datapath.sv
`default_nettype none

module bdq_datapath #(
  parameter int unsigned DEPTH = 8
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire bdq_pkg::ctrl_cmd_t          cmd,
  output bdq_pkg::dp_stat_t                stat,
  input  wire logic [1:0]                  opcode,
  input  wire logic signed [bdq_pkg::DATA_W-1:0] value,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic signed [bdq_pkg::DATA_W-1:0] data_out,
  output logic [1:0]                       status
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CW:0] DEPTH_W = (CW + 1)'(DEPTH);

  // Slot storage; read port is registered.
  logic [bdq_pkg::DATA_W-1:0] mem [DEPTH];
  logic [bdq_pkg::DATA_W-1:0] rd_data;

  // Queue pointers.
  logic [CW-1:0] head;
  logic [CW-1:0] count;

  // Captured request.
  logic [1:0]                 req_op;
  logic [bdq_pkg::DATA_W-1:0] req_value;

  // Pending result between execution and delivery.
  logic [1:0] res_status;
  logic       res_use_rd;

  logic [CW:0]   pos;
  logic [CW-1:0] head_dec;
  logic          rear_full;
  logic          front_full;
  logic          pop_empty;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic          rd_en;
  logic [1:0]    exec_status;

  // Condition checks on the current pointers.
  always_comb begin
    pos        = {1'b0, head} + {1'b0, count};
    head_dec   = head - CW'(1);
    rear_full  = (pos >= DEPTH_W);
    front_full = (head == '0) || ({1'b0, head} > DEPTH_W);
    pop_empty  = (count == '0) || ({1'b0, head} >= DEPTH_W);
  end

  // Decide the memory access and the status of the current request.
  always_comb begin
    wr_en       = 1'b0;
    wr_addr     = pos[AW-1:0];
    rd_en       = 1'b0;
    exec_status = bdq_pkg::ST_OK;
    case (req_op)
      bdq_pkg::OP_PUSH_REAR: begin
        if (rear_full) begin
          exec_status = bdq_pkg::ST_FULL;
        end else begin
          wr_en = cmd.exec;
        end
      end
      bdq_pkg::OP_PUSH_FRONT: begin
        wr_addr = head_dec[AW-1:0];
        if (front_full) begin
          exec_status = bdq_pkg::ST_FULL;
        end else begin
          wr_en = cmd.exec;
        end
      end
      bdq_pkg::OP_POP_FRONT: begin
        if (pop_empty) begin
          exec_status = bdq_pkg::ST_EMPTY;
        end else begin
          rd_en = cmd.exec;
        end
      end
      default: begin
        exec_status = bdq_pkg::ST_OK;
      end
    endcase
  end

  // Slot memory: one write or one registered read per cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= req_value;
    end
    if (rd_en) begin
      rd_data <= mem[head[AW-1:0]];
    end
  end

  // Request capture and pending result.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_op    <= opcode;
      req_value <= value;
    end
    if (cmd.exec) begin
      res_status <= exec_status;
      res_use_rd <= rd_en;
    end
  end

  // Pointer updates.
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else if (cmd.exec) begin
      if (wr_en) begin
        count <= count + CW'(1);
        if (req_op == bdq_pkg::OP_PUSH_FRONT) begin
          head <= head_dec;
        end
      end else if (rd_en) begin
        head  <= head + CW'(1);
        count <= count - CW'(1);
      end
    end
  end

  // Output register; it frees up as soon as the consumer takes the item.
  assign stat.res_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.deliver) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.deliver) begin
      status <= res_status;
      if (res_use_rd) begin
        data_out <= rd_data;
      end else if (res_status == bdq_pkg::ST_EMPTY) begin
        data_out <= '1;
      end else begin
        data_out <= '0;
      end
    end
  end

`ifndef SYNTH
  // The occupied run never reaches past the top of the array.
  a_run_in_range: assert property (@(posedge clk) disable iff (rst)
    pos <= DEPTH_W)
    else $error("occupied slots extend past the array");

  // A successful pop moves the head up and shrinks the count by one.
  a_pop_update: assert property (@(posedge clk) disable iff (rst)
    rd_en |=> (head == $past(head) + CW'(1)) && (count == $past(count) - CW'(1)))
    else $error("pop did not update the pointers");

  // A successful front push moves the head down and grows the count.
  a_front_push_update: assert property (@(posedge clk) disable iff (rst)
    (wr_en && (req_op == bdq_pkg::OP_PUSH_FRONT)) |=>
      (head == $past(head) - CW'(1)) && (count == $past(count) + CW'(1)))
    else $error("front push did not update the pointers");

  // A result is only delivered when the output register can take it.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.deliver |-> (!out_valid || out_ready))
    else $error("result delivered over a pending item");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/bounded_array_deque.sv
`default_nettype none

// Channel  Handshake               Payload
// -------  ----------------------  ----------------------------------
// in       in_valid / in_ready     opcode[1:0], value[31:0] signed
// out      out_valid / out_ready   data_out[31:0] signed, status[1:0]
//
// Each item goes through capture, one access to the single-port slot memory
// with the pointer update, and the load of the output register.
// A stalled output holds the block in its final step until the item is taken.
// Reset clears the controller state, the output valid, head and count; the
// slots need no clearing pass.
// The next item is taken while the previous result waits at the output.

module bounded_array_deque #(
  parameter int unsigned DEPTH = 8
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [1:0]                         opcode,
  input  wire logic signed [bdq_pkg::DATA_W-1:0]  value,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic signed [bdq_pkg::DATA_W-1:0]       data_out,
  output logic [1:0]                              status
);

  bdq_pkg::ctrl_cmd_t cmd;
  bdq_pkg::dp_stat_t  stat;

  // Sequencer.
  bdq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Slot memory, pointers and output register.
  bdq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .opcode    (opcode),
    .value     (value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .data_out  (data_out),
    .status    (status)
  );

endmodule

`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned DEPTH = 8;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned RANDOM_ITEMS = 1325;
  localparam int unsigned HOLD_CYCLES = 300;
  // The block leaves this code unused and must ignore it.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]         op;
    logic signed [31:0] val;
  } deque_req_t;

  typedef struct {
    logic signed [31:0] data;
    logic [1:0]         status;
  } deque_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] opcode = bdq_pkg::OP_PUSH_REAR;
  logic signed [31:0] value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] data_out;
  logic [1:0] status;

  bounded_array_deque #(.DEPTH(DEPTH)) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .opcode(opcode),
    .value(value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .data_out(data_out),
    .status(status)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Requests waiting to be driven, and results the deque owes us.
  deque_req_t    request_queue[$];
  deque_result_t owed_results[$];

  // Shadow copy of the deque contents.
  logic signed [31:0] shadow_slot [DEPTH];
  int unsigned shadow_head = 0;
  int unsigned shadow_count = 0;

  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches = 0;
  int unsigned n_push_ok = 0;
  int unsigned n_pop_ok = 0;
  int unsigned n_full = 0;
  int unsigned n_empty = 0;
  int unsigned n_unused = 0;
  int unsigned max_fill = 0;
  int unsigned cycle_count = 0;

  int src_gap = 0;
  int snk_gap = 0;
  int src_burst = 0;
  int snk_burst = 0;
  logic sink_hold = 1'b0;

  // Apply one request to the shadow deque and queue the result it must produce.
  function automatic void deque_apply(input logic [1:0] op, input logic signed [31:0] val);
    deque_result_t r;
    r.data = '0;
    r.status = bdq_pkg::ST_OK;
    case (op)
      bdq_pkg::OP_PUSH_REAR: begin
        if (shadow_head + shadow_count >= DEPTH) begin
          r.status = bdq_pkg::ST_FULL;
          n_full++;
        end else begin
          shadow_slot[shadow_head + shadow_count] = val;
          shadow_count++;
          n_push_ok++;
        end
      end
      bdq_pkg::OP_PUSH_FRONT: begin
        if (shadow_head == 0) begin
          r.status = bdq_pkg::ST_FULL;
          n_full++;
        end else begin
          shadow_head--;
          shadow_slot[shadow_head] = val;
          shadow_count++;
          n_push_ok++;
        end
      end
      bdq_pkg::OP_POP_FRONT: begin
        if (shadow_count == 0) begin
          r.data = -32'sd1;
          r.status = bdq_pkg::ST_EMPTY;
          n_empty++;
        end else begin
          r.data = shadow_slot[shadow_head];
          shadow_head++;
          shadow_count--;
          n_pop_ok++;
        end
      end
      default: n_unused++;
    endcase
    if (shadow_count > max_fill) max_fill = shadow_count;
    owed_results.push_back(r);
  endfunction

  // Mostly short gaps, a few long ones, and now and then a run with none at all.
  function automatic int pick_gap(inout int burst_left);
    int roll;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      burst_left = $urandom_range(20, 60);
      return 0;
    end
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  // Data words favor the corners of the signed range.
  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'sh0000_0000;
      1: return -32'sd1;
      2: return 32'sh7FFF_FFFF;
      3: return 32'sh8000_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic void add_request(input logic [1:0] op, input logic signed [31:0] val);
    deque_req_t q;
    q.op = op;
    q.val = val;
    request_queue.push_back(q);
  endfunction

  task automatic report_mismatch(input string what, input logic signed [31:0] got,
                                 input logic signed [31:0] want);
    mismatches++;
    if (mismatches <= 20)
      $display("mismatch at result %0d: %s got %0d, wanted %0d",
               results_seen, what, got, want);
  endtask

  // Sender: an item is taken when valid and ready meet; predict it, then offer the next.
  always @(posedge clk) begin
    deque_req_t q;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        deque_apply(opcode, value);
        items_sent++;
      end
      if (!in_valid || in_ready) begin
        if (src_gap > 0) begin
          src_gap <= src_gap - 1;
          in_valid <= 1'b0;
        end else if (request_queue.size() > 0) begin
          q = request_queue.pop_front();
          in_valid <= 1'b1;
          opcode <= q.op;
          value <= q.val;
          src_gap <= pick_gap(src_burst);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each item against the oldest owed result, then pick the next stall.
  always @(posedge clk) begin
    deque_result_t want;
    int g;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (owed_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 20)
            $display("unexpected item: data %0d status %0d", data_out, status);
        end else begin
          want = owed_results.pop_front();
          if (data_out !== want.data) report_mismatch("data_out", data_out, want.data);
          if (status !== want.status) report_mismatch("status", status, want.status);
        end
        results_seen++;
      end
      if (sink_hold) begin
        out_ready <= 1'b0;
      end else if (snk_gap > 0) begin
        snk_gap <= snk_gap - 1;
        out_ready <= 1'b0;
      end else if (out_valid && out_ready) begin
        g = pick_gap(snk_burst);
        out_ready <= (g == 0);
        snk_gap <= (g > 0) ? g - 1 : 0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still owed", cycle_count,
               owed_results.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    int made;
    int block_len;
    int mode;
    int roll;
    logic [1:0] op;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed part: empty pop, front full on an empty deque, fill to the top,
    // both full cases, the unused code, then drain so the head ends at the top.
    add_request(bdq_pkg::OP_POP_FRONT, 32'sd5);
    add_request(bdq_pkg::OP_PUSH_FRONT, 32'sd9);
    add_request(bdq_pkg::OP_PUSH_REAR, 32'sh7FFF_FFFF);
    add_request(bdq_pkg::OP_PUSH_REAR, 32'sh8000_0000);
    add_request(bdq_pkg::OP_PUSH_REAR, 32'sh0000_0000);
    add_request(bdq_pkg::OP_PUSH_REAR, -32'sd1);
    add_request(bdq_pkg::OP_PUSH_REAR, 32'sh5555_5555);
    add_request(bdq_pkg::OP_PUSH_REAR, 32'shAAAA_AAAA);
    add_request(bdq_pkg::OP_PUSH_REAR, 32'sd1);
    add_request(bdq_pkg::OP_PUSH_REAR, 32'sd2);
    add_request(bdq_pkg::OP_PUSH_REAR, 32'sd3);
    add_request(bdq_pkg::OP_PUSH_FRONT, 32'sd4);
    add_request(OP_UNUSED, 32'sh1234_5678);
    repeat (3) add_request(bdq_pkg::OP_POP_FRONT, 32'sh0);
    add_request(bdq_pkg::OP_PUSH_FRONT, 32'sh0F0F_F0F0);
    repeat (6) add_request(bdq_pkg::OP_POP_FRONT, 32'sh0);
    add_request(bdq_pkg::OP_POP_FRONT, -32'sd1);
    add_request(bdq_pkg::OP_PUSH_REAR, 32'sd6);
    add_request(bdq_pkg::OP_PUSH_FRONT, 32'sd7);

    while (request_queue.size() > 0 || in_valid || owed_results.size() > 0)
      @(posedge clk);

    // Random part: runs that lean toward filling, draining or a mix.
    made = 0;
    while (made < RANDOM_ITEMS) begin
      mode = $urandom_range(0, 2);
      block_len = $urandom_range(10, 50);
      repeat (block_len) begin
        roll = $urandom_range(0, 99);
        if (roll < 2) op = OP_UNUSED;
        else if ((mode == 0 && roll < 75) || (mode == 1 && roll < 30) ||
                 (mode == 2 && roll < 55))
          op = $urandom_range(0, 1) ? bdq_pkg::OP_PUSH_FRONT : bdq_pkg::OP_PUSH_REAR;
        else op = bdq_pkg::OP_POP_FRONT;
        add_request(op, pick_value());
        made++;
      end
    end

    // Hold the output off long enough for the block to back up and stall its input.
    while (items_sent < 300 && request_queue.size() > 0) @(posedge clk);
    sink_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    sink_hold <= 1'b0;

    while (request_queue.size() > 0 || in_valid || owed_results.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);

    $display("%0d items: %0d pushes stored, %0d pops returned data, %0d full, %0d empty,",
             items_sent, n_push_ok, n_pop_ok, n_full, n_empty);
    $display("%0d unused codes, deepest fill %0d of %0d, %0d results checked",
             n_unused, max_fill, DEPTH, results_seen);
    if (mismatches == 0 && owed_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches, %0d results never arrived", mismatches,
               owed_results.size());
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
